// ===== rtl/muq_pkg.sv =====
// Shared types and codes for the mission upload sequencer.
// Depends on nothing; used by every module of the block.
`default_nettype none
package muq_pkg;

    localparam logic [2:0] FUNC_LOAD    = 3'd0;
    localparam logic [2:0] FUNC_START   = 3'd1;
    localparam logic [2:0] FUNC_REQ_INT = 3'd2;
    localparam logic [2:0] FUNC_REQ_PLN = 3'd3;
    localparam logic [2:0] FUNC_ACK     = 3'd4;
    localparam logic [2:0] FUNC_TICK    = 3'd5;
    localparam logic [2:0] FUNC_FAILED  = 3'd6;
    localparam logic [2:0] FUNC_CANCEL  = 3'd7;

    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_COUNT     = 3'd1;
    localparam logic [2:0] KIND_ITEM      = 3'd2;
    localparam logic [2:0] KIND_ACK_UNSUP = 3'd3;
    localparam logic [2:0] KIND_ACK_CANC  = 3'd4;

    localparam logic [3:0] RES_RUNNING    = 4'd0;
    localparam logic [3:0] RES_SUCCESS    = 4'd1;
    localparam logic [3:0] RES_CONNECTION = 4'd2;
    localparam logic [3:0] RES_EMPTY      = 4'd3;
    localparam logic [3:0] RES_SEQUENCE   = 4'd4;
    localparam logic [3:0] RES_CURRENT    = 4'd5;
    localparam logic [3:0] RES_TYPE       = 4'd6;
    localparam logic [3:0] RES_INT_UNSUP  = 4'd7;
    localparam logic [3:0] RES_TIMEOUT    = 4'd8;
    localparam logic [3:0] RES_PROTOCOL   = 4'd9;
    localparam logic [3:0] RES_FRAME      = 4'd10;
    localparam logic [3:0] RES_UNSUP      = 4'd11;
    localparam logic [3:0] RES_NO_SPACE   = 4'd12;
    localparam logic [3:0] RES_PARAM      = 4'd13;
    localparam logic [3:0] RES_DENIED     = 4'd14;
    localparam logic [3:0] RES_CANCELLED  = 4'd15;

    localparam logic [2:0] REG_PLAN_TYPE    = 3'd0;
    localparam logic [2:0] REG_RETRY_LIMIT  = 3'd1;
    localparam logic [2:0] REG_TIMEOUT      = 3'd2;
    localparam logic [2:0] REG_INT_SUP      = 3'd3;
    localparam logic [2:0] REG_PLAIN_AS_INT = 3'd4;

    typedef struct packed {
        logic [7:0]  plan_type;
        logic [3:0]  retry_limit;
        logic [15:0] timeout_ticks;
        logic        int_supported;
        logic        plain_request_as_int;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] item_seq;
        logic        item_current;
        logic [7:0]  item_plan_type;
        logic [15:0] msg_value;
    } event_t;

    typedef struct packed {
        logic [2:0]  send_kind;
        logic [15:0] send_value;
        logic        finished;
        logic [3:0]  result_code;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/muq_cfg_regs.sv =====
// Configuration register file of the mission upload sequencer.
// Depends on muq_pkg for the register indexes and the cfg_t bundle.
`default_nettype none
module muq_cfg_regs
    import muq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PLAN_TYPE:    cfg_next.plan_type            = cfg_wdata[7:0];
                REG_RETRY_LIMIT:  cfg_next.retry_limit          = cfg_wdata[3:0];
                REG_TIMEOUT:      cfg_next.timeout_ticks        = cfg_wdata;
                REG_INT_SUP:      cfg_next.int_supported        = cfg_wdata[0];
                REG_PLAIN_AS_INT: cfg_next.plain_request_as_int = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.plan_type            <= 8'd0;
            cfg_reg.retry_limit          <= 4'd4;
            cfg_reg.timeout_ticks        <= 16'd1000;
            cfg_reg.int_supported        <= 1'b1;
            cfg_reg.plain_request_as_int <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/muq_core.sv =====
// Transfer state and event handling of the mission upload sequencer.
// Depends on muq_pkg; the result is combinational and registered by the top level.
`default_nettype none
module muq_core
    import muq_pkg::*;
#(
    parameter int SEQ_WIDTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  cfg_t      cfg,
    input  wire logic ev_fire,
    input  event_t    ev,
    output result_t   res
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_ITEMS = 2'd2;
    localparam logic [SEQ_WIDTH-1:0] SEQ_MASK = {SEQ_WIDTH{1'b1}};
    localparam logic [SEQ_WIDTH-1:0] SEQ_ONE  = SEQ_WIDTH'(1);

    logic [SEQ_WIDTH-1:0] item_total_reg, item_total_next;
    logic [SEQ_WIDTH-1:0] next_index_reg, next_index_next;
    logic [3:0]           retries_reg, retries_next;
    logic [1:0]           phase_reg, phase_next;
    logic [15:0]          timer_reg, timer_next;
    logic                 running_reg, running_next;
    logic                 seq_bad_reg, seq_bad_next;
    logic [1:0]           cur_total_reg, cur_total_next;
    logic                 type_bad_reg, type_bad_next;

    logic                 active;
    logic [SEQ_WIDTH-1:0] iseq;
    logic [SEQ_WIDTH-1:0] rseq;
    logic [15:0]          timer_inc;
    logic [15:0]          tick_limit;
    logic [3:0]           retries_base;

    function automatic logic [3:0] bump(input logic [3:0] r);
        bump = (r == 4'd15) ? r : r + 4'd1;
    endfunction

    function automatic logic [3:0] ack_code(input logic [15:0] code, input logic all_sent);
        case (code)
            16'd1:  ack_code = RES_PROTOCOL;
            16'd2:  ack_code = RES_FRAME;
            16'd3:  ack_code = RES_UNSUP;
            16'd4:  ack_code = RES_NO_SPACE;
            16'd5, 16'd6, 16'd7, 16'd8, 16'd9, 16'd10, 16'd11, 16'd12:
                    ack_code = RES_PARAM;
            16'd13: ack_code = RES_SEQUENCE;
            16'd14: ack_code = RES_DENIED;
            16'd15: ack_code = RES_CANCELLED;
            default: ack_code = all_sent ? RES_SUCCESS : RES_PROTOCOL;
        endcase
    endfunction

    assign active     = (phase_reg == PH_COUNT) || (phase_reg == PH_ITEMS);
    assign iseq       = ev.item_seq[SEQ_WIDTH-1:0];
    assign rseq       = ev.msg_value[SEQ_WIDTH-1:0];
    assign timer_inc  = timer_reg + 16'd1;
    assign tick_limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
    assign retries_base = (next_index_reg == rseq) ? 4'd0 : retries_reg;

    always_comb begin
        item_total_next = item_total_reg;
        next_index_next = next_index_reg;
        retries_next    = retries_reg;
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        running_next    = running_reg;
        seq_bad_next    = seq_bad_reg;
        cur_total_next  = cur_total_reg;
        type_bad_next   = type_bad_reg;
        res.send_kind   = KIND_NONE;
        res.send_value  = 16'd0;
        res.finished    = 1'b0;
        res.result_code = RES_RUNNING;

        if ((ev.func == FUNC_LOAD) || (ev.func == FUNC_START)) begin
            if (!active && (ev.func == FUNC_LOAD)) begin
                if (item_total_reg == SEQ_MASK) begin
                    seq_bad_next = 1'b1;
                end else begin
                    if (iseq != item_total_reg) begin
                        seq_bad_next = 1'b1;
                    end
                    item_total_next = item_total_reg + SEQ_ONE;
                end
                if (ev.item_current && (cur_total_reg != 2'd2)) begin
                    cur_total_next = cur_total_reg + 2'd1;
                end
                if (ev.item_plan_type != cfg.plan_type) begin
                    type_bad_next = 1'b1;
                end
            end else if (!active) begin
                res.finished = 1'b1;
                if (!cfg.int_supported) begin
                    res.result_code = RES_INT_UNSUP;
                end else if (item_total_reg == '0) begin
                    res.result_code = RES_EMPTY;
                end else if (seq_bad_reg) begin
                    res.result_code = RES_SEQUENCE;
                end else if (cur_total_reg != 2'd1) begin
                    res.result_code = RES_CURRENT;
                end else if (type_bad_reg) begin
                    res.result_code = RES_TYPE;
                end else begin
                    res.finished    = 1'b0;
                    phase_next      = PH_COUNT;
                    retries_next    = 4'd1;
                    next_index_next = '0;
                    timer_next      = 16'd0;
                    running_next    = 1'b1;
                    res.send_kind   = KIND_COUNT;
                    res.send_value  = 16'(item_total_reg);
                end
            end
        end else if (active) begin
            unique case (ev.func)
                FUNC_REQ_INT, FUNC_REQ_PLN: begin
                    if ((ev.func == FUNC_REQ_PLN) && !cfg.plain_request_as_int) begin
                        timer_next    = 16'd0;
                        res.send_kind = KIND_ACK_UNSUP;
                    end else begin
                        phase_next = PH_ITEMS;
                        if (next_index_reg < rseq) begin
                            res.send_kind = KIND_NONE;
                        end else if ((next_index_reg > rseq) &&
                                     (retries_reg >= cfg.retry_limit)) begin
                            res.finished    = 1'b1;
                            res.result_code = RES_TIMEOUT;
                        end else begin
                            retries_next    = retries_base;
                            timer_next      = 16'd0;
                            next_index_next = rseq;
                            if (rseq < item_total_reg) begin
                                res.send_kind   = KIND_ITEM;
                                res.send_value  = 16'(rseq);
                                next_index_next = rseq + SEQ_ONE;
                                retries_next    = bump(retries_base);
                            end
                        end
                    end
                end
                FUNC_ACK: begin
                    res.finished    = 1'b1;
                    res.result_code = ack_code(ev.msg_value,
                                               next_index_reg == item_total_reg);
                end
                FUNC_TICK: begin
                    if (running_reg) begin
                        if (timer_inc < tick_limit) begin
                            timer_next = timer_inc;
                        end else if (retries_reg >= cfg.retry_limit) begin
                            res.finished    = 1'b1;
                            res.result_code = RES_TIMEOUT;
                        end else begin
                            timer_next   = 16'd0;
                            retries_next = bump(retries_reg);
                            if (phase_reg == PH_COUNT) begin
                                res.send_kind  = KIND_COUNT;
                                res.send_value = 16'(item_total_reg);
                            end
                        end
                    end
                end
                FUNC_FAILED: begin
                    res.finished    = 1'b1;
                    res.result_code = RES_CONNECTION;
                end
                FUNC_CANCEL: begin
                    res.finished    = 1'b1;
                    res.send_kind   = KIND_ACK_CANC;
                    res.result_code = RES_CANCELLED;
                end
                default: begin
                    res.send_kind = KIND_NONE;
                end
            endcase
        end

        if (res.finished) begin
            item_total_next = '0;
            next_index_next = '0;
            retries_next    = 4'd0;
            phase_next      = PH_IDLE;
            timer_next      = 16'd0;
            running_next    = 1'b0;
            seq_bad_next    = 1'b0;
            cur_total_next  = 2'd0;
            type_bad_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_total_reg <= '0;
            next_index_reg <= '0;
            retries_reg    <= 4'd0;
            phase_reg      <= PH_IDLE;
            timer_reg      <= 16'd0;
            running_reg    <= 1'b0;
            seq_bad_reg    <= 1'b0;
            cur_total_reg  <= 2'd0;
            type_bad_reg   <= 1'b0;
        end else if (ev_fire) begin
            item_total_reg <= item_total_next;
            next_index_reg <= next_index_next;
            retries_reg    <= retries_next;
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            running_reg    <= running_next;
            seq_bad_reg    <= seq_bad_next;
            cur_total_reg  <= cur_total_next;
            type_bad_reg   <= type_bad_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mission_upload_sequencer.sv =====
// Mission upload sequencer, top level: input register, event core, result register.
// Path: a transaction accepted into the input register passes through muq_core and is
// captured in the result register that drives m_tvalid, once that register is free or
// m_tready is high. Throughput: one event per cycle unless m_tready stalls the output.
// Reset: synchronous, active low; clears the transfer state, both stage valids
// and loads the configuration defaults. Depends on muq_pkg, muq_cfg_regs, muq_core.
`default_nettype none
module mission_upload_sequencer
    import muq_pkg::*;
#(
    parameter int SEQ_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: item_seq[15:0], item_current[16], item_plan_type[24:17],
    // msg_value[40:25], zero padding[47:41].
    input  wire logic [47:0] s_tdata,
    // Fields from bit 0: func[2:0].
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: send_value[15:0], result_code[19:16], zero padding[23:20].
    output logic [23:0]      m_tdata,
    // Fields from bit 0: send_kind[2:0].
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    cfg_t    cfg;
    event_t  ev_reg;
    logic    ev_valid_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = ev_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !ev_valid_reg || advance;

    muq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    muq_core #(
        .SEQ_WIDTH (SEQ_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .ev_fire (advance),
        .ev      (ev_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                ev_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ev_reg.func           <= s_tuser;
            ev_reg.item_seq       <= s_tdata[15:0];
            ev_reg.item_current   <= s_tdata[16];
            ev_reg.item_plan_type <= s_tdata[24:17];
            ev_reg.msg_value      <= s_tdata[40:25];
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg.result_code, res_reg.send_value};
    assign m_tuser  = res_reg.send_kind;
    assign m_tlast  = res_reg.finished;

endmodule
`default_nettype wire
